@@ hw/rtl/btvd_pkg.sv @@
// Shared types, constants and helper functions of the binlog temporal value decoder.
// Used by btvd_bcd_pipe and binlog_temporal_value_decoder; depends on nothing.
`default_nettype none

package btvd_pkg;

	localparam int unsigned InW = 72;
	localparam int unsigned OutW = 64;

	localparam int unsigned BinW = 64;
	localparam int unsigned Digits = 20;
	localparam int unsigned BcdW = 4 * Digits;
	localparam int unsigned ConvW = BcdW + BinW;
	localparam int unsigned ConvStages = 16;
	localparam int unsigned StepsPerStage = BinW / ConvStages;

	// Stages s1 to s3 run beside the converter before the delay line starts.
	localparam int unsigned DlyStages = ConvStages - 3;

	localparam int unsigned YmW = 18;
	localparam int unsigned Div13MultW = 19;
	localparam int unsigned ProdW = YmW + Div13MultW;
	localparam int unsigned Div13Shift = 22;
	localparam logic [Div13MultW-1:0] Div13Mult = 19'd322639;

	localparam logic [39:0] Dt2Offset = 40'h80_0000_0000;
	localparam logic [14:0] YearBase = 15'd1900;
	localparam logic [13:0] YearMax = 14'd16383;

	typedef enum logic [2:0] {
		KIND_YEAR      = 3'd0,
		KIND_DATE      = 3'd1,
		KIND_TIME      = 3'd2,
		KIND_DATETIME  = 3'd3,
		KIND_DATETIME2 = 3'd4
	} kind_t;

	typedef struct packed {
		logic signed [14:0] year;
		logic signed [7:0]  mon;
		logic [6:0]         day;
		logic [10:0]        hour;
		logic [6:0]         minute;
		logic [6:0]         second;
	} fields_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] size;
		fields_t    f;
	} meta_t;

	// A few shift-and-add-three steps of binary to decimal conversion.
	function automatic logic [ConvW-1:0] conv_steps(input logic [ConvW-1:0] v);
		logic [ConvW-1:0] a;
		a = v;
		for (int s = 0; s < StepsPerStage; s++) begin
			for (int d = 0; d < Digits; d++) begin
				if (a[BinW + 4*d +: 4] > 4'd4) begin
					a[BinW + 4*d +: 4] = a[BinW + 4*d +: 4] + 4'd3;
				end
			end
			a = {a[ConvW-2:0], 1'b0};
		end
		return a;
	endfunction

	function automatic logic [6:0] digit_pair(input logic [3:0] hi, input logic [3:0] lo);
		return 7'(hi) * 7'd10 + 7'(lo);
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/btvd_bcd_pipe.sv @@
// Pipelined binary to decimal converter, a fixed number of bit steps per stage.
// Depends on btvd_pkg.
`default_nettype none

module btvd_bcd_pipe (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [btvd_pkg::BinW-1:0]     bin_in,
	output logic      [btvd_pkg::BcdW-1:0]     bcd_out
);

	logic [btvd_pkg::ConvW-1:0] work_s [btvd_pkg::ConvStages];
	logic [btvd_pkg::ConvW-1:0] feed   [btvd_pkg::ConvStages];

	assign feed[0] = {{btvd_pkg::BcdW{1'b0}}, bin_in};

	for (genvar g = 1; g < btvd_pkg::ConvStages; g++) begin : g_feed
		assign feed[g] = work_s[g-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < btvd_pkg::ConvStages; i++) begin
				work_s[i] <= btvd_pkg::conv_steps(feed[i]);
			end
		end
	end

	assign bcd_out = work_s[btvd_pkg::ConvStages-1][btvd_pkg::ConvW-1 -: btvd_pkg::BcdW];

endmodule

`default_nettype wire

@@ hw/rtl/binlog_temporal_value_decoder.sv @@
// Top level of the binlog temporal value decoder: input decode, month and year split,
// decimal conversion and result register. Depends on btvd_pkg and btvd_bcd_pipe.
//
// One input item on s_* carries a kind, up to eight stored bytes and the fractional
// digit count of the column; one result item on m_* carries the calendar fields and
// the stored size of the value. Every input item gives exactly one result item.
// The block is an 18-stage pipeline with valid bits: s1, s2, s3, the delay line, s17
// and the s18 result register. While the output is not stalled a new item may enter
// every cycle, so the sustained rate is one item per cycle.
// The depth is set by the decimal conversion of the 64-bit legacy datetime value,
// which runs four bits per stage over sixteen stages.
// While a result waits with m_tready low, the whole pipeline holds and s_tready is
// low; nothing is lost or repeated. Reset clears all valid bits, so the pipeline
// comes up empty and ready to accept items.
`default_nettype none

module binlog_temporal_value_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// func [2:0], stored_bytes [66:3], fraction_digits [69:67], zero [71:70]
	input  wire logic [btvd_pkg::InW-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// year_since_1900 [14:0], month_index [22:15], day_of_month [29:23],
	// hour_value [40:30], minute_value [47:41], second_value [54:48],
	// bytes_used [58:55], zero [63:59]
	output logic      [btvd_pkg::OutW-1:0]     m_tdata
);

	logic en;

	btvd_pkg::kind_t   in_kind;
	logic [63:0]       in_sb;
	logic [2:0]        in_fd;
	logic [2:0]        fd_cl;
	logic [39:0]       raw;
	logic [39:0]       mag;
	logic [13:0]       date_sat;
	btvd_pkg::meta_t   in_meta;
	logic [63:0]       conv_in;
	logic [btvd_pkg::BcdW-1:0] conv_bcd;

	logic                          valid_s1;
	btvd_pkg::meta_t               meta_s1;
	logic [btvd_pkg::YmW-1:0]      ym_s1;

	logic                          valid_s2;
	btvd_pkg::meta_t               meta_s2;
	logic [btvd_pkg::YmW-1:0]      ym_s2;
	logic [btvd_pkg::ProdW-1:0]    prod_s2;

	logic [14:0]                   q13;
	logic [3:0]                    r13;
	btvd_pkg::meta_t               meta3_d;

	logic                          valid_s3;
	btvd_pkg::meta_t               meta_s3;

	logic                          dly_valid_s [btvd_pkg::DlyStages];
	btvd_pkg::meta_t               dly_s       [btvd_pkg::DlyStages];

	logic                          valid_s17;
	btvd_pkg::meta_t               meta_s17;
	logic [6:0]                    sec_s17;
	logic [6:0]                    min_s17;
	logic [6:0]                    hr2_s17;
	logic [6:0]                    day_s17;
	logic [6:0]                    mon_s17;
	logic [10:0]                   hour4_s17;
	logic [16:0]                   year5_s17;
	logic                          yhi_s17;

	btvd_pkg::fields_t             out_d;
	logic [13:0]                   dt_year;

	logic                          valid_s18;
	btvd_pkg::fields_t             fields_s18;
	logic [3:0]                    size_s18;

	assign en = !valid_s18 || m_tready;
	assign s_tready = en;

	always_comb begin
		in_kind = btvd_pkg::kind_t'(s_tdata[2:0]);
		in_sb = s_tdata[66:3];
		in_fd = s_tdata[69:67];
		fd_cl = (in_fd > 3'd6) ? 3'd6 : in_fd;
		raw = {in_sb[7:0], in_sb[15:8], in_sb[23:16], in_sb[31:24], in_sb[39:32]};
		mag = raw[39] ? {1'b0, raw[38:0]} : (btvd_pkg::Dt2Offset - raw);
		date_sat = in_sb[23] ? btvd_pkg::YearMax : in_sb[22:9];
		conv_in = (in_kind == btvd_pkg::KIND_TIME) ? {40'd0, in_sb[23:0]} : in_sb;
		in_meta = '0;
		in_meta.kind = in_kind;
		case (in_kind)
			btvd_pkg::KIND_YEAR: begin
				in_meta.f.year = 15'(in_sb[7:0]);
				in_meta.size = 4'd1;
			end
			btvd_pkg::KIND_DATE: begin
				in_meta.f.day = 7'(in_sb[4:0]);
				in_meta.f.mon = 8'(in_sb[8:5]) - 8'd1;
				in_meta.f.year = 15'(date_sat) - btvd_pkg::YearBase;
				in_meta.size = 4'd3;
			end
			btvd_pkg::KIND_TIME: begin
				in_meta.size = 4'd3;
			end
			btvd_pkg::KIND_DATETIME: begin
				in_meta.size = 4'd8;
			end
			btvd_pkg::KIND_DATETIME2: begin
				in_meta.f.second = 7'(mag[5:0]);
				in_meta.f.minute = 7'(mag[11:6]);
				in_meta.f.hour = 11'(mag[16:12]);
				in_meta.f.day = 7'(mag[21:17]);
				in_meta.size = 4'd5 + 4'((fd_cl + 3'd1) >> 1);
			end
			default: begin
				in_meta.size = 4'd0;
			end
		endcase
	end

	btvd_bcd_pipe u_bcd (
		.clk     (clk),
		.en      (en),
		.bin_in  (conv_in),
		.bcd_out (conv_bcd)
	);

	// The year and month of the datetime2 kind come from dividing by 13.
	always_comb begin
		q13 = prod_s2[btvd_pkg::ProdW-1:btvd_pkg::Div13Shift];
		r13 = 4'(ym_s2 - btvd_pkg::YmW'(btvd_pkg::YmW'(q13) * btvd_pkg::YmW'(13)));
		meta3_d = meta_s2;
		if (meta_s2.kind == btvd_pkg::KIND_DATETIME2) begin
			meta3_d.f.year = q13 - btvd_pkg::YearBase;
			meta3_d.f.mon = 8'(r13) - 8'd1;
		end
	end

	always_comb begin
		dt_year = (yhi_s17 || (year5_s17 > 17'(btvd_pkg::YearMax))) ?
			btvd_pkg::YearMax : year5_s17[13:0];
		out_d = '0;
		case (meta_s17.kind)
			btvd_pkg::KIND_YEAR, btvd_pkg::KIND_DATE, btvd_pkg::KIND_DATETIME2: begin
				out_d = meta_s17.f;
			end
			btvd_pkg::KIND_TIME: begin
				out_d.hour = hour4_s17;
				out_d.minute = min_s17;
				out_d.second = sec_s17;
			end
			btvd_pkg::KIND_DATETIME: begin
				out_d.year = 15'(dt_year) - btvd_pkg::YearBase;
				out_d.mon = 8'(mon_s17) - 8'd1;
				out_d.day = day_s17;
				out_d.hour = 11'(hr2_s17);
				out_d.minute = min_s17;
				out_d.second = sec_s17;
			end
			default: begin
				out_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			for (int i = 0; i < btvd_pkg::DlyStages; i++) begin
				dly_valid_s[i] <= 1'b0;
			end
			valid_s17 <= 1'b0;
			valid_s18 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			dly_valid_s[0] <= valid_s3;
			for (int i = 1; i < btvd_pkg::DlyStages; i++) begin
				dly_valid_s[i] <= dly_valid_s[i-1];
			end
			valid_s17 <= dly_valid_s[btvd_pkg::DlyStages-1];
			valid_s18 <= valid_s17;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= in_meta;
			ym_s1 <= mag[39:22];

			meta_s2 <= meta_s1;
			ym_s2 <= ym_s1;
			prod_s2 <= btvd_pkg::ProdW'(ym_s1) * btvd_pkg::ProdW'(btvd_pkg::Div13Mult);

			meta_s3 <= meta3_d;

			dly_s[0] <= meta_s3;
			for (int i = 1; i < btvd_pkg::DlyStages; i++) begin
				dly_s[i] <= dly_s[i-1];
			end

			meta_s17 <= dly_s[btvd_pkg::DlyStages-1];
			sec_s17 <= btvd_pkg::digit_pair(conv_bcd[7:4], conv_bcd[3:0]);
			min_s17 <= btvd_pkg::digit_pair(conv_bcd[15:12], conv_bcd[11:8]);
			hr2_s17 <= btvd_pkg::digit_pair(conv_bcd[23:20], conv_bcd[19:16]);
			day_s17 <= btvd_pkg::digit_pair(conv_bcd[31:28], conv_bcd[27:24]);
			mon_s17 <= btvd_pkg::digit_pair(conv_bcd[39:36], conv_bcd[35:32]);
			hour4_s17 <= 11'(14'(conv_bcd[31:28]) * 14'd1000 + 14'(conv_bcd[27:24]) * 14'd100
				+ 14'(conv_bcd[23:20]) * 14'd10 + 14'(conv_bcd[19:16]));
			year5_s17 <= 17'(conv_bcd[59:56]) * 17'd10000 + 17'(conv_bcd[55:52]) * 17'd1000
				+ 17'(conv_bcd[51:48]) * 17'd100 + 17'(conv_bcd[47:44]) * 17'd10
				+ 17'(conv_bcd[43:40]);
			yhi_s17 <= |conv_bcd[79:60];

			fields_s18 <= out_d;
			size_s18 <= meta_s17.size;
		end
	end

	assign m_tvalid = valid_s18;
	assign m_tdata = {5'd0, size_s18, fields_s18.second, fields_s18.minute, fields_s18.hour,
		fields_s18.day, fields_s18.mon, fields_s18.year};

endmodule

`default_nettype wire
